// ===== rtl/rsb_pkg.sv =====
// Shared types, constants and latency helpers for the reassigned spectrum bin core.
`default_nettype none

package rsb_pkg;

    // Default fractional bits of the Q formats on the data path
    localparam int DEF_FRAC_BITS = 16;

    // Reset value of the power regularizer register
    localparam logic [15:0] EPS_RESET = 16'd4295;

    // ln(2) in Q0.26
    localparam logic [25:0] LN2_Q26 = 26'd46516320;

    // pi in Q16 and the clamp of the Q2.13 phase output
    localparam int PHASE_PI_Q16 = 205887;
    localparam int PHASE_MAX    = 25736;

    // CORDIC rotation count and arctangent table, Q16 radians
    localparam int ATAN_STEPS = 17;
    localparam logic [16:0] ATAN_TAB [ATAN_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024,  17'd512,   17'd256,   17'd128,  17'd64,   17'd32,
        17'd16,    17'd8,     17'd4,     17'd2,    17'd1
    };

    // Stage counts of the fixed-depth units
    localparam int SQRT_STAGES = 32;
    localparam int LOG_STAGES  = 35;
    localparam int ATAN_LAT    = 3 + ATAN_STEPS + 1;

    // Divider latency: setup, one stage per quotient bit, final clamp
    function automatic int div_latency(input int frac_bits);
        return 34 + frac_bits;
    endfunction

    // Front-end results handed to the parallel units
    typedef struct packed {
        logic [63:0]        power;
        logic [63:0]        denom;
        logic [3:0]         num_neg;
        logic [3:0][63:0]   num_mag;
        logic signed [31:0] x_re;
        logic signed [31:0] x_im;
    } front_t;

endpackage

`default_nettype wire

// ===== rtl/reassigned_spectrum_bin_core.sv =====
// Top level of the reassigned spectrum bin core.
`default_nettype none

// Per FFT bin this core takes X, Dh and Th (complex, Q15.16) and returns the
// magnitude, ln of power, the atan2 phase (Q2.13) and the ratios Dh/X and
// Th/X as dM/dt, dPhi/dt, dM/dw and dPhi/dw, all saturating. It accepts one
// bin per clock while no result is held at the output; its latency is set by
// the divider, which spends one stage per quotient bit, and the root, log and
// phase units are padded to match. The whole pipe freezes while a result
// waits at the output, so back-pressure is taken without loss.
// power_epsilon may be written only while no bin is in flight.
module reassigned_spectrum_bin_core #(
    parameter int FRAC_BITS = rsb_pkg::DEF_FRAC_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // power_epsilon register write
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    // input bins
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // x_re, x_im, dh_re, dh_im, th_re, th_im (32 bits each, from bit 0 up)
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // magnitude, log_power (32), phase (16), dmag_dt, dphase_dt, dmag_dw,
    // dphase_dw (32 each), from bit 0 up
    output logic [207:0]      m_tdata,
    output logic              m_tlast
);

    localparam int LAT   = rsb_pkg::div_latency(FRAC_BITS);
    localparam int TOTAL = 3 + LAT;

    logic [15:0]       eps_reg;
    logic              en;
    rsb_pkg::front_t   front;
    logic [31:0]       magnitude, log_power;
    logic [15:0]       phase;
    logic [3:0][31:0]  ratio;
    logic [1:0]        ctl_out;

    // Regularizer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= rsb_pkg::EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // Whole pipe advances unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Valid and frame marker travel alongside the data
    rsb_delay #(
        .WIDTH (2),
        .DEPTH (TOTAL)
    ) u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({s_tlast, s_tvalid}),
        .dout  (ctl_out)
    );

    assign m_tvalid = ctl_out[0];
    assign m_tlast  = ctl_out[1];

    rsb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .en            (en),
        .power_epsilon (eps_reg),
        .x_re          (s_tdata[31:0]),
        .x_im          (s_tdata[63:32]),
        .dh_re         (s_tdata[95:64]),
        .dh_im         (s_tdata[127:96]),
        .th_re         (s_tdata[159:128]),
        .th_im         (s_tdata[191:160]),
        .front         (front)
    );

    rsb_sqrt #(
        .LAT (LAT)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .power     (front.power),
        .magnitude (magnitude)
    );

    rsb_log #(
        .FRAC_BITS (FRAC_BITS),
        .LAT       (LAT)
    ) u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .power     (front.power),
        .log_power (log_power)
    );

    rsb_atan #(
        .LAT (LAT)
    ) u_atan (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .x_re  (front.x_re),
        .x_im  (front.x_im),
        .phase (phase)
    );

    // Four ratio dividers: Re(Dh/X), Im(Dh/X), -Im(Th/X), Re(Th/X)
    for (genvar k = 0; k < 4; k++)
    begin : g_div
        rsb_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num_mag (front.num_mag[k]),
            .num_neg (front.num_neg[k]),
            .denom   (front.denom),
            .quot    (ratio[k])
        );
    end

    assign m_tdata = {ratio[3], ratio[2], ratio[1], ratio[0], phase, log_power, magnitude};

endmodule

`default_nettype wire

// ===== rtl/rsb_delay.sv =====
// Enabled shift-register delay line with asynchronous clear.
`default_nettype none

module rsb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/rsb_front.sv =====
// Front end: products, power, signed numerators and regularized denominator.
`default_nettype none

module rsb_front #(
    parameter int FRAC_BITS = rsb_pkg::DEF_FRAC_BITS
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [15:0]        power_epsilon,
    input  wire logic signed [31:0] x_re,
    input  wire logic signed [31:0] x_im,
    input  wire logic signed [31:0] dh_re,
    input  wire logic signed [31:0] dh_im,
    input  wire logic signed [31:0] th_re,
    input  wire logic signed [31:0] th_im,
    output rsb_pkg::front_t         front
);

    localparam int EPS_LSH = 2 * FRAC_BITS - 32;
    localparam int EPS_RSH = 32 - 2 * FRAC_BITS;

    logic signed [63:0] prod_reg [10];
    logic signed [31:0] xr1_reg, xi1_reg, xr2_reg, xi2_reg;
    logic [63:0]        pow2_reg;
    logic signed [64:0] nsum_reg [4];
    logic [63:0]        eps_w;
    rsb_pkg::front_t    front_reg;

    // Regularizer scaled to 2*FRAC_BITS fractional bits
    if (EPS_LSH >= 0)
    begin : g_eps_left
        assign eps_w = 64'(power_epsilon) << EPS_LSH;
    end
    else
    begin : g_eps_right
        assign eps_w = 64'(power_epsilon) >> EPS_RSH;
    end

    // Stage 1: all ten products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= x_re * x_re;
            prod_reg[1] <= x_im * x_im;
            prod_reg[2] <= dh_re * x_re;
            prod_reg[3] <= dh_im * x_im;
            prod_reg[4] <= dh_im * x_re;
            prod_reg[5] <= dh_re * x_im;
            prod_reg[6] <= th_re * x_im;
            prod_reg[7] <= th_im * x_re;
            prod_reg[8] <= th_re * x_re;
            prod_reg[9] <= th_im * x_im;
            xr1_reg     <= x_re;
            xi1_reg     <= x_im;
        end
    end

    // Stage 2: power and the four cross sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pow2_reg    <= 64'(prod_reg[0] + prod_reg[1]);
            nsum_reg[0] <= 65'(prod_reg[2]) + 65'(prod_reg[3]);
            nsum_reg[1] <= 65'(prod_reg[4]) - 65'(prod_reg[5]);
            nsum_reg[2] <= 65'(prod_reg[6]) - 65'(prod_reg[7]);
            nsum_reg[3] <= 65'(prod_reg[8]) + 65'(prod_reg[9]);
            xr2_reg     <= xr1_reg;
            xi2_reg     <= xi1_reg;
        end
    end

    // Stage 3: sign and magnitude of numerators, denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg.power <= pow2_reg;
            front_reg.denom <= pow2_reg + eps_w;
            for (int k = 0; k < 4; k++)
            begin
                front_reg.num_neg[k] <= nsum_reg[k][64];
                front_reg.num_mag[k] <= nsum_reg[k][64] ? 64'(-nsum_reg[k])
                                                        : nsum_reg[k][63:0];
            end
            front_reg.x_re <= xr2_reg;
            front_reg.x_im <= xi2_reg;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// ===== rtl/rsb_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rsb_sqrt #(
    parameter int LAT = rsb_pkg::div_latency(rsb_pkg::DEF_FRAC_BITS)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [63:0] power,
    output logic      [31:0] magnitude
);

    localparam int N = rsb_pkg::SQRT_STAGES;

    logic [63:0] v_reg [N];
    logic [63:0] r_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
        logic [63:0] v_in, r_in, trial;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign v_in = power;
            assign r_in = '0;
        end
        else
        begin : g_next
            assign v_in = v_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        // Trial subtract of res + bit
        always_comb
        begin
            trial = r_in + BIT;
            ge    = v_in >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j] <= ge ? v_in - trial : v_in;
                r_reg[j] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
            end
        end
    end

    // Align with the divider latency
    rsb_delay #(
        .WIDTH (32),
        .DEPTH (LAT - N)
    ) u_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (r_reg[N-1][31:0]),
        .dout  (magnitude)
    );

endmodule

`default_nettype wire

// ===== rtl/rsb_log.sv =====
// Natural log of power: leading-one search, squaring log2 loop, scale by ln 2.
`default_nettype none

module rsb_log #(
    parameter int FRAC_BITS = rsb_pkg::DEF_FRAC_BITS,
    parameter int LAT       = rsb_pkg::div_latency(rsb_pkg::DEF_FRAC_BITS)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [63:0] power,
    output logic      [31:0] log_power
);

    localparam int NSQ = 30;
    localparam int SH  = 56 - FRAC_BITS;
    localparam logic signed [63:0] RND = 64'sd1 <<< (SH - 1);
    localparam logic [55:0] LN2_W = 56'(rsb_pkg::LN2_Q26);

    // Stage A: per-byte leading one
    logic [63:0] pa_reg;
    logic        za_reg;
    logic [7:0]  nz_reg;
    logic [2:0]  pos_reg [8];
    logic [2:0]  pos_w [8];

    // Highest set bit inside each byte
    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            pos_w[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (power[8*g + b])
                begin
                    pos_w[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= power;
            za_reg <= power == '0;
            for (int g = 0; g < 8; g++)
            begin
                nz_reg[g]  <= |power[8*g +: 8];
                pos_reg[g] <= pos_w[g];
            end
        end
    end

    // Stage B: pick the highest nonzero byte
    logic [63:0] pb_reg;
    logic        zb_reg;
    logic [5:0]  kb_reg;
    logic [5:0]  kb_w;

    always_comb
    begin
        kb_w = '0;
        for (int g = 0; g < 8; g++)
        begin
            if (nz_reg[g])
            begin
                kb_w = {3'(g), pos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb_reg <= pa_reg;
            zb_reg <= za_reg;
            kb_reg <= kb_w;
        end
    end

    // Stage C: normalize mantissa to [2^31, 2^32)
    logic [31:0] m_reg [NSQ+1];
    logic [29:0] f_reg [NSQ+1];
    logic [5:0]  k_reg [NSQ+1];
    logic        z_reg [NSQ+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= (kb_reg >= 6'd31) ? 32'(pb_reg >> (kb_reg - 6'd31))
                                          : 32'(pb_reg << (6'd31 - kb_reg));
            f_reg[0] <= '0;
            k_reg[0] <= kb_reg;
            z_reg[0] <= zb_reg;
        end
    end

    // Squaring steps, one log2 fraction bit each
    for (genvar j = 0; j < NSQ; j++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;

        always_comb
        begin
            sq = m_reg[j] * m_reg[j];
            t  = sq[63:31];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[j+1] <= t[32] ? t[32:1] : t[31:0];
                f_reg[j+1] <= {f_reg[j][28:0], t[32]};
                k_reg[j+1] <= k_reg[j];
                z_reg[j+1] <= z_reg[j];
            end
        end
    end

    // Scale stage 1: split product with ln 2
    logic [55:0]        pf_reg;
    logic signed [35:0] pk_reg;
    logic               zf_reg;
    logic signed [7:0]  li_w;

    assign li_w = $signed({2'b00, k_reg[NSQ]}) - 8'(2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pf_reg <= f_reg[NSQ] * LN2_W;
            pk_reg <= li_w * $signed({1'b0, rsb_pkg::LN2_Q26});
            zf_reg <= z_reg[NSQ];
        end
    end

    // Scale stage 2: combine, round half up, saturate
    logic signed [63:0] v_w, r_w;
    logic [31:0]        out_reg;

    always_comb
    begin
        v_w = (64'(pk_reg) <<< 30) + $signed({8'b0, pf_reg});
        r_w = (v_w + RND) >>> SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (zf_reg)
            begin
                out_reg <= 32'h8000_0000;
            end
            else if (r_w > 64'sd2147483647)
            begin
                out_reg <= 32'h7FFF_FFFF;
            end
            else if (r_w < -64'sd2147483648)
            begin
                out_reg <= 32'h8000_0000;
            end
            else
            begin
                out_reg <= r_w[31:0];
            end
        end
    end

    // Align with the divider latency
    rsb_delay #(
        .WIDTH (32),
        .DEPTH (LAT - rsb_pkg::LOG_STAGES)
    ) u_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (out_reg),
        .dout  (log_power)
    );

endmodule

`default_nettype wire

// ===== rtl/rsb_atan.sv =====
// Phase by atan2: quadrant fold, normalize, 17 CORDIC vectoring stages.
`default_nettype none

module rsb_atan #(
    parameter int LAT = rsb_pkg::div_latency(rsb_pkg::DEF_FRAC_BITS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic signed [31:0] x_re,
    input  wire logic signed [31:0] x_im,
    output logic             [15:0] phase
);

    localparam int N = rsb_pkg::ATAN_STEPS;
    localparam logic signed [20:0] PI_Q16 = 21'(rsb_pkg::PHASE_PI_Q16);
    localparam logic signed [20:0] PH_MAX = 21'(rsb_pkg::PHASE_MAX);

    // Stage A: fold left half-plane, take max magnitude
    logic signed [33:0] xa_w, ya_w, ay_w;
    logic signed [33:0] xa_reg, ya_reg;
    logic signed [20:0] aa_reg;
    logic [31:0]        mx_reg;
    logic               za_reg;

    always_comb
    begin
        xa_w = x_re[31] ? -34'(x_re) : 34'(x_re);
        ya_w = x_re[31] ? -34'(x_im) : 34'(x_im);
        ay_w = ya_w[33] ? -ya_w : ya_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg <= xa_w;
            ya_reg <= ya_w;
            aa_reg <= x_re[31] ? (x_im[31] ? -PI_Q16 : PI_Q16) : '0;
            mx_reg <= (xa_w > ay_w) ? xa_w[31:0] : ay_w[31:0];
            za_reg <= (x_re == '0) && (x_im == '0);
        end
    end

    // Stage B: leading one of the max magnitude
    logic signed [33:0] xb_reg, yb_reg;
    logic signed [20:0] ab_reg;
    logic [5:0]         shb_reg;
    logic               zb_reg;
    logic [4:0]         msb_w;

    always_comb
    begin
        msb_w = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (mx_reg[b])
            begin
                msb_w = 5'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            ab_reg  <= aa_reg;
            shb_reg <= 6'd39 - 6'(msb_w);
            zb_reg  <= za_reg;
        end
    end

    // Stage C and the rotation stages
    logic signed [43:0] x_reg [N+1];
    logic signed [43:0] y_reg [N+1];
    logic signed [20:0] a_reg [N+1];
    logic               z_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= 44'(xb_reg) <<< shb_reg;
            y_reg[0] <= 44'(yb_reg) <<< shb_reg;
            a_reg[0] <= ab_reg;
            z_reg[0] <= zb_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [20:0] ANG = $signed(21'(rsb_pkg::ATAN_TAB[i]));
        logic signed [43:0] xs, ys;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][43])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - ANG;
                end
                z_reg[i+1] <= z_reg[i];
            end
        end
    end

    // Final: Q16 to Q2.13, round half up, clamp
    logic signed [20:0] ph_w;
    logic [15:0]        out_reg;

    assign ph_w = (a_reg[N] + 21'sd4) >>> 3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (z_reg[N])
            begin
                out_reg <= '0;
            end
            else if (ph_w > PH_MAX)
            begin
                out_reg <= PH_MAX[15:0];
            end
            else if (ph_w < -PH_MAX)
            begin
                out_reg <= 16'(-PH_MAX);
            end
            else
            begin
                out_reg <= ph_w[15:0];
            end
        end
    end

    // Align with the divider latency
    rsb_delay #(
        .WIDTH (16),
        .DEPTH (LAT - rsb_pkg::ATAN_LAT)
    ) u_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (out_reg),
        .dout  (phase)
    );

endmodule

`default_nettype wire

// ===== rtl/rsb_div.sv =====
// Pipelined restoring divider: saturated signed num * 2^FRAC_BITS / denom.
`default_nettype none

module rsb_div #(
    parameter int FRAC_BITS = rsb_pkg::DEF_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] num_mag,
    input  wire logic        num_neg,
    input  wire logic [63:0] denom,
    output logic      [31:0] quot
);

    localparam int NQ = 32 + FRAC_BITS;

    logic [63:0]   rem_reg [NQ+1];
    logic [NQ-1:0] low_reg [NQ+1];
    logic [NQ-1:0] q_reg   [NQ+1];
    logic [63:0]   d_reg   [NQ+1];
    logic          neg_reg [NQ+1];
    logic          ovf_reg [NQ+1];
    logic          dz_reg  [NQ+1];

    // Setup: integer-part overflow and zero divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 64'(num_mag[63:32]);
            low_reg[0] <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
            q_reg[0]   <= '0;
            d_reg[0]   <= denom;
            neg_reg[0] <= num_neg;
            ovf_reg[0] <= 64'(num_mag[63:32]) >= denom;
            dz_reg[0]  <= denom == '0;
        end
    end

    // One quotient bit per stage
    for (genvar j = 0; j < NQ; j++)
    begin : g_bit
        logic [64:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[j], low_reg[j][NQ-1]};
            ge    = trial >= {1'b0, d_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? 64'(trial - {1'b0, d_reg[j]}) : trial[63:0];
                low_reg[j+1] <= low_reg[j] << 1;
                q_reg[j+1]   <= {q_reg[j][NQ-2:0], ge};
                d_reg[j+1]   <= d_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                dz_reg[j+1]  <= dz_reg[j];
            end
        end
    end

    // Final: clamp to signed range, apply sign
    logic [31:0] lim_w, qv_w;
    logic [31:0] out_reg;

    always_comb
    begin
        lim_w = neg_reg[NQ] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qv_w  = (ovf_reg[NQ] || (q_reg[NQ] > NQ'(lim_w))) ? lim_w : q_reg[NQ][31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= dz_reg[NQ] ? '0 : (neg_reg[NQ] ? -qv_w : qv_w);
        end
    end

    assign quot = out_reg;

endmodule

`default_nettype wire
